// ----- src/lcd4_pkg.sv -----
// Shared types, codes and init sequence tables for the 4-bit character LCD driver.
// No dependencies; the other files except lcd4_if take names from here by scope.
`default_nettype none

package lcd4_pkg;

    localparam int LINE_CHARS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int INIT_NIBBLES   = 12;

    localparam logic [12:0] WAIT_CMD     = 13'd40;
    localparam logic [12:0] WAIT_CLEAR   = 13'd2040;
    localparam logic [12:0] WAIT_INIT0   = 13'd4100;
    localparam logic [12:0] WAIT_INIT1   = 13'd100;
    localparam logic [13:0] WAIT_POWERUP = 14'd15000;

    localparam logic [7:0] BYTE_CLEAR    = 8'h01;
    localparam logic [7:0] BYTE_LINE1    = 8'h80;
    localparam logic [7:0] BYTE_LINE2    = 8'hC0;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_INSTR = 3'd1,
        CMD_DATA  = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_CURS  = 3'd4,
        CMD_START = 3'd5,
        CMD_CHAR  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        PH_SETUP = 2'd0,
        PH_STROBE = 2'd1,
        PH_HOLD  = 2'd2
    } phase_t;

    // one queued job: either the init sequence or a byte, optionally followed
    // by the line-two cursor byte
    typedef struct packed {
        logic       is_init;
        logic [7:0] byte_a;
        logic       rs_a;
        logic       clear_wait;
        logic       has_b;
    } job_t;

    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] n;
        case (idx)
            4'd0:    n = 4'h3;
            4'd1:    n = 4'h3;
            4'd2:    n = 4'h3;
            4'd3:    n = 4'h2;
            4'd4:    n = 4'h2;
            4'd5:    n = 4'h8;
            4'd6:    n = 4'h0;
            4'd7:    n = 4'hC;
            4'd8:    n = 4'h0;
            4'd9:    n = 4'h1;
            4'd10:   n = 4'h0;
            4'd11:   n = 4'h6;
            default: n = 4'h0;
        endcase
        return n;
    endfunction

    function automatic logic [12:0] init_wait(input logic [3:0] idx);
        logic [12:0] w;
        case (idx)
            4'd0:    w = WAIT_INIT0;
            4'd1:    w = WAIT_INIT1;
            4'd2:    w = WAIT_CMD;
            4'd3:    w = WAIT_CMD;
            4'd5:    w = WAIT_CMD;
            4'd7:    w = WAIT_CMD;
            4'd9:    w = WAIT_CLEAR;
            4'd11:   w = WAIT_CMD;
            default: w = 13'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/lcd4_if.sv -----
// Valid/ready channel interfaces: command beats in, port-write beats out.
// No dependencies.
`default_nettype none

interface lcd4_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] value;

    modport source (output valid, cmd, value, input ready);
    modport sink (input valid, cmd, value, output ready);
endinterface

interface lcd4_wr_if;
    logic        valid;
    logic        ready;
    logic [5:0]  port_bits;
    logic [13:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;

    modport source (output valid, port_bits, wait_before_us, wait_after_us, last,
                    input ready);
    modport sink (input valid, port_bits, wait_before_us, wait_after_us, last,
                  output ready);
endinterface

`default_nettype wire

// ----- src/lcd4_front.sv -----
// Front end: accepts command beats, tracks the string character count and
// turns each command into a job for the queue. Uses lcd4_pkg and lcd4_cmd_if.
`default_nettype none

module lcd4_front #(
    parameter int LINE_CHARS = lcd4_pkg::LINE_CHARS_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    lcd4_cmd_if.sink         req,
    input  wire              q_full,
    output logic             push,
    output lcd4_pkg::job_t   push_job
);
    localparam int CW = $clog2(LINE_CHARS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          accept;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        push            = accept;
        count_next      = count_reg;
        push_job        = '0;
        push_job.byte_a = req.value;
        case (lcd4_pkg::cmd_t'(req.cmd))
            lcd4_pkg::CMD_INIT:
            begin
                push_job.is_init = 1'b1;
            end
            lcd4_pkg::CMD_INSTR:
            begin
                push_job.byte_a = req.value;
            end
            lcd4_pkg::CMD_DATA:
            begin
                push_job.rs_a = 1'b1;
            end
            lcd4_pkg::CMD_CLEAR:
            begin
                push_job.byte_a     = lcd4_pkg::BYTE_CLEAR;
                push_job.clear_wait = 1'b1;
            end
            lcd4_pkg::CMD_CURS:
            begin
                push_job.byte_a = ((req.value[7:4] == 4'h0) ? lcd4_pkg::BYTE_LINE1
                                                            : lcd4_pkg::BYTE_LINE2)
                                  | {4'h0, req.value[3:0]};
            end
            lcd4_pkg::CMD_START:
            begin
                push_job.byte_a     = lcd4_pkg::BYTE_CLEAR;
                push_job.clear_wait = 1'b1;
                if (accept)
                    count_next = '0;
            end
            lcd4_pkg::CMD_CHAR:
            begin
                push_job.rs_a  = 1'b1;
                push_job.has_b = (count_reg == CW'(LINE_CHARS - 1));
                if (accept && (count_reg < CW'(LINE_CHARS)))
                    count_next = count_reg + 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire

// ----- src/lcd4_queue.sv -----
// Small job queue between the front end and the write sequencer.
// Uses lcd4_pkg for the job type and depth.
`default_nettype none

module lcd4_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  lcd4_pkg::job_t  push_job,
    input  wire             pop,
    output logic            full,
    output logic            nempty,
    output lcd4_pkg::job_t  head
);
    localparam int DEPTH = lcd4_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    lcd4_pkg::job_t mem [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [CNTW-1:0] count_reg;

    assign full   = (count_reg == CNTW'(DEPTH));
    assign nempty = (count_reg != '0);
    assign head   = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            count_reg <= count_reg + CNTW'(push) - CNTW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nempty)
        else $error("job popped from empty queue");

endmodule

`default_nettype wire

// ----- src/lcd4_back.sv -----
// Write sequencer: expands the head job into nibble writes (setup, E high,
// hold) into a registered output beat. Uses lcd4_pkg and lcd4_wr_if.
`default_nettype none

module lcd4_back (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             nempty,
    input  lcd4_pkg::job_t  head,
    output logic            pop,
    lcd4_wr_if.source       wr
);
    lcd4_pkg::phase_t ph_reg, ph_next;
    logic [3:0]  idx_reg, idx_next;
    logic        vld_reg;
    logic [5:0]  bits_reg;
    logic [13:0] wb_reg;
    logic [12:0] wa_reg;
    logic        last_reg;

    logic        ld;
    logic        last_w;
    logic [3:0]  nib_total;
    logic [3:0]  nib;
    logic        rs;
    logic [5:0]  bits_w;
    logic [13:0] wb_w;
    logic [12:0] wa_w;

    assign ld = nempty && (!vld_reg || wr.ready);

    // next phase and nibble index
    always_comb
    begin
        nib_total = head.is_init ? 4'(lcd4_pkg::INIT_NIBBLES) : (head.has_b ? 4'd4 : 4'd2);
        last_w    = (idx_reg == nib_total - 4'd1) && (ph_reg == lcd4_pkg::PH_HOLD);
        ph_next   = ph_reg;
        idx_next  = idx_reg;
        if (ld)
        begin
            case (ph_reg)
                lcd4_pkg::PH_SETUP:  ph_next = lcd4_pkg::PH_STROBE;
                lcd4_pkg::PH_STROBE: ph_next = lcd4_pkg::PH_HOLD;
                default:
                begin
                    ph_next  = lcd4_pkg::PH_SETUP;
                    idx_next = last_w ? 4'd0 : idx_reg + 4'd1;
                end
            endcase
        end
        pop = ld && last_w;
    end

    // write contents for the current phase
    always_comb
    begin
        wb_w = 14'd0;
        wa_w = 13'd0;
        if (head.is_init)
        begin
            nib = lcd4_pkg::init_nibble(idx_reg);
            rs  = 1'b0;
            if (ph_reg == lcd4_pkg::PH_HOLD)
                wa_w = lcd4_pkg::init_wait(idx_reg);
            if ((idx_reg == 4'd0) && (ph_reg == lcd4_pkg::PH_SETUP))
                wb_w = lcd4_pkg::WAIT_POWERUP;
        end
        else
        begin
            case (idx_reg[1:0])
                2'd0:    nib = head.byte_a[7:4];
                2'd1:    nib = head.byte_a[3:0];
                2'd2:    nib = lcd4_pkg::BYTE_LINE2[7:4];
                default: nib = lcd4_pkg::BYTE_LINE2[3:0];
            endcase
            rs = head.rs_a && !idx_reg[1];
            if (ph_reg == lcd4_pkg::PH_HOLD)
            begin
                if (idx_reg == 4'd1)
                    wa_w = head.clear_wait ? lcd4_pkg::WAIT_CLEAR : lcd4_pkg::WAIT_CMD;
                else if (idx_reg == 4'd3)
                    wa_w = lcd4_pkg::WAIT_CMD;
            end
        end
        bits_w = {rs, (ph_reg == lcd4_pkg::PH_STROBE), nib};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= lcd4_pkg::PH_SETUP;
            idx_reg <= 4'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            ph_reg  <= ph_next;
            idx_reg <= idx_next;
            if (ld)
                vld_reg <= 1'b1;
            else if (wr.ready)
                vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            bits_reg <= bits_w;
            wb_reg   <= wb_w;
            wa_reg   <= wa_w;
            last_reg <= last_w;
        end
    end

    assign wr.valid          = vld_reg;
    assign wr.port_bits      = bits_reg;
    assign wr.wait_before_us = wb_reg;
    assign wr.wait_after_us  = wa_reg;
    assign wr.last           = last_reg;

    a_strobe_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && wr.port_bits[4]) |-> (wr.wait_after_us == 13'd0 && !wr.last))
        else $error("E high on a hold or final beat");
    a_powerup_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && wr.wait_before_us != 14'd0) |-> (wr.port_bits == 6'h03))
        else $error("power-up wait on a beat other than first init write");

endmodule

`default_nettype wire

// ----- src/char_lcd_4bit_interface_unit.sv -----
// Top level of the 4-bit character LCD driver: front end, job queue, sequencer.
// Depends on lcd4_pkg, lcd4_if, lcd4_front, lcd4_queue and lcd4_back.
//
// req carries command beats (cmd, value); wr carries one beat per port write
// (port_bits, wait_before_us, wait_after_us, last). The consumer applies the
// waits; last marks the final write of a command.
// Writes come out one per cycle while wr.ready is high and a job is queued;
// a nibble goes out as setup, E high and hold writes. Init sends the init
// table; instruction, data, clear, cursor and string start one byte; a string
// char that wraps to line two adds the line-two cursor byte. Code 7 is taken
// and dropped. A command's first write passes through the queue (written at
// the accepting edge) and the output register, loaded once the sequencer
// reaches the job and the output is free. A two-entry job queue lets new
// commands be taken while the sequencer works; req.ready drops only when
// the queue is full. With a beat valid and wr.ready low, the beat holds and
// the sequencer pauses. Reset empties the queue, clears valid and string count.
`default_nettype none

module char_lcd_4bit_interface_unit #(
    parameter int LINE_CHARS = lcd4_pkg::LINE_CHARS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    lcd4_cmd_if.sink    req,
    lcd4_wr_if.source   wr
);
    logic           push;
    lcd4_pkg::job_t push_job;
    logic           q_full;
    logic           q_nempty;
    logic           pop;
    lcd4_pkg::job_t head;

    lcd4_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    lcd4_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .nempty   (q_nempty),
        .head     (head)
    );

    lcd4_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .nempty (q_nempty),
        .head   (head),
        .pop    (pop),
        .wr     (wr)
    );

endmodule

`default_nettype wire
